FILE: hdl/edf_task_selector_assert.svh
// ----------------------------------------------------------------------------
// edf_task_selector assertion macros
// concurrent assertion wrappers clocked on clk, included by edf_task_selector.sv
// ----------------------------------------------------------------------------
`ifndef EDF_TASK_SELECTOR_ASSERT_SVH
`define EDF_TASK_SELECTOR_ASSERT_SVH

// checked only outside reset
`define EDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define EDF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// types and constants of the earliest-deadline-first task selector
// ----------------------------------------------------------------------------
package edf_pkg;

	localparam int TASK_SLOTS_DEF = 16;

	localparam logic [63:0] NO_DEADLINE = '1;

	localparam logic [1:0] ST_REGISTERED = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_SELECTED   = 2'd2;
	localparam logic [1:0] ST_NONE       = 2'd3;

	localparam logic REQ_REGISTER = 1'b0;
	localparam logic REQ_SCHEDULE = 1'b1;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_UPDATE,
		FSM_DONE
	} fsm_t;

	typedef struct packed {
		logic [63:0] period;
		logic [63:0] deadline;
		logic [63:0] prev_run;
	} entry_t;

endpackage

FILE: hdl/edf_task_selector.sv
// sequence: a register request writes its slot when accepted, unless the table is full,
// and queues its result beat from the done state; a schedule request reads the slots
// in order, compares each registered read, then writes back the selected task in the
// update state, skipped when none is ready; one slot read per cycle via the single read port
// throughput: one request at a time, the next accepted the cycle after the result is queued
// reset: clears the task count and control state; slots above the count are never read
// ----------------------------------------------------------------------------
// edf_task_selector
// earliest-deadline-first task selector over a table held in one memory
// ----------------------------------------------------------------------------
`include "edf_task_selector_assert.svh"

module edf_task_selector
	import edf_pkg::*;
#(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [63:0] period,
	input  logic [63:0] now_ms,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [3:0]  task_index,
	output logic [4:0]  task_total
);

	localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);

	entry_t mem [TASK_SLOTS];

	fsm_t             state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] scan_q;
	logic             rvalid_s1;
	logic [IDX_W-1:0] ridx_s1;
	entry_t           rdata_s1;
	logic             found_q;
	logic [IDX_W-1:0] best_q;
	logic [63:0]      best_dl_q;
	logic [63:0]      best_period_q;
	logic [63:0]      now_q;
	logic [1:0]       res_status_q;
	logic [IDX_W-1:0] res_idx_q;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [CNT_W-1:0] out_total_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             rd_en;
	logic             accept;
	logic             table_full;
	logic             task_ready;
	logic             out_free;
	logic [IDX_W+3:0] idx_ext;
	logic [CNT_W+4:0] total_ext;

	assign accept     = req_valid && !req_stall;
	assign table_full = (cnt_q >= CNT_W'(TASK_SLOTS));
	assign task_ready = ((now_q - rdata_s1.prev_run) >= rdata_s1.period);
	assign out_free   = !out_valid_q || !rsp_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = best_q;
		mem_wdata = '0;
		rd_en     = 1'b0;
		req_stall = 1'b1;
		unique case (state_q)
			FSM_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req_type == REQ_REGISTER) begin
						state_d = FSM_DONE;
						if (!table_full) begin
							mem_we    = 1'b1;
							mem_waddr = cnt_q[IDX_W-1:0];
							mem_wdata = '{period: period, deadline: now_ms + period,
								prev_run: 64'd0};
						end
					end else begin
						state_d = FSM_SCAN;
					end
				end
			end
			FSM_SCAN: begin
				rd_en = (scan_q < cnt_q);
				// leave once every read has been issued and compared
				if (!rd_en && !rvalid_s1) begin
					state_d = found_q ? FSM_UPDATE : FSM_DONE;
				end
			end
			FSM_UPDATE: begin
				mem_we    = 1'b1;
				mem_waddr = best_q;
				mem_wdata = '{period: best_period_q, deadline: now_q + best_period_q,
					prev_run: now_q};
				state_d   = FSM_DONE;
			end
			FSM_DONE: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// task table, read data registered
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[scan_q[IDX_W-1:0]];
		end
	end

	// datapath and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			scan_q        <= '0;
			rvalid_s1     <= 1'b0;
			ridx_s1       <= '0;
			found_q       <= 1'b0;
			best_q        <= '0;
			best_dl_q     <= NO_DEADLINE;
			best_period_q <= '0;
			now_q         <= '0;
			res_status_q  <= ST_NONE;
			res_idx_q     <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= ST_NONE;
			out_idx_q     <= '0;
			out_total_q   <= '0;
		end else begin
			rvalid_s1 <= rd_en;
			if (accept) begin
				now_q <= now_ms;
				if (req_type == REQ_REGISTER) begin
					if (table_full) begin
						res_status_q <= ST_FULL;
						res_idx_q    <= '0;
					end else begin
						res_status_q <= ST_REGISTERED;
						res_idx_q    <= cnt_q[IDX_W-1:0];
						cnt_q        <= cnt_q + 1'b1;
					end
				end else begin
					scan_q    <= '0;
					found_q   <= 1'b0;
					best_dl_q <= NO_DEADLINE;
				end
			end
			if (rd_en) begin
				scan_q  <= scan_q + 1'b1;
				ridx_s1 <= scan_q[IDX_W-1:0];
			end
			// strict less-than keeps the lowest index on ties and skips all-ones deadlines
			if (rvalid_s1 && task_ready && (rdata_s1.deadline < best_dl_q)) begin
				found_q       <= 1'b1;
				best_q        <= ridx_s1;
				best_dl_q     <= rdata_s1.deadline;
				best_period_q <= rdata_s1.period;
			end
			if (state_q == FSM_SCAN && state_d == FSM_DONE) begin
				res_status_q <= ST_NONE;
				res_idx_q    <= '0;
			end
			if (state_q == FSM_UPDATE) begin
				res_status_q <= ST_SELECTED;
				res_idx_q    <= best_q;
			end
			if (state_q == FSM_DONE && out_free) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_idx_q    <= res_idx_q;
				out_total_q  <= cnt_q;
			end else if (rsp_valid && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign idx_ext   = {4'd0, out_idx_q};
	assign total_ext = {5'd0, out_total_q};

	assign rsp_valid  = out_valid_q;
	assign status     = out_status_q;
	assign task_index = idx_ext[3:0];
	assign task_total = total_ext[4:0];

	`EDF_ASSERT(a_count_bound, cnt_q <= CNT_W'(TASK_SLOTS), "task count above table size")
	`EDF_ASSERT(a_no_write_in_scan, (state_q == FSM_SCAN) |-> !mem_we, "table written during scan")
	`EDF_ASSERT(a_sel_in_range, (state_q == FSM_UPDATE) |-> (CNT_W'(best_q) < cnt_q), "selected slot not registered")
	`EDF_ASSERT(a_reg_counts, (accept && req_type == REQ_REGISTER && !table_full) |=> (cnt_q == $past(cnt_q) + 1'b1), "register did not advance task count")

endmodule
